@@ sv/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the character LCD sequencer RTL.
// Every property is sampled on the rising edge of clk and is switched off
// while the synchronous reset rst_n is held low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold on every clock edge outside reset.
`define CLW_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// When the trigger holds on one edge, the consequence must hold on the next.
`define CLW_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/clwseq_pkg.sv @@
// ---------------------------------------------------------------------------
// clwseq_pkg
// Types, constants and helper functions of the character LCD write
// sequencer: item layouts, register indexes, power-up steps and phases.
// ---------------------------------------------------------------------------
`default_nettype none

package clwseq_pkg;

  // Width of the tick counter; durations longer than it can hold are clipped.
  localparam int COUNT_WIDTH = 24;
  localparam logic [32:0] CNT_MAX = (33'd1 << COUNT_WIDTH) - 33'd1;
  localparam logic [COUNT_WIDTH-1:0] CNT_ONE = COUNT_WIDTH'(1);

  // Configuration port.
  localparam int CFG_W     = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SETUP      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENABLE     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HOLD       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_POWER_WAIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE2_WAIT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WAKE3_WAIT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_CLEAR_WAIT = 3'd6;

  // Reset values of the timing registers.
  localparam logic [15:0] RST_SETUP      = 16'd12;
  localparam logic [15:0] RST_ENABLE     = 16'd90;
  localparam logic [15:0] RST_HOLD       = 16'd240;
  localparam logic [23:0] RST_POWER_WAIT = 24'd4000000;
  localparam logic [23:0] RST_WAKE2_WAIT = 24'd800000;
  localparam logic [23:0] RST_WAKE3_WAIT = 24'd20000;
  localparam logic [23:0] RST_CLEAR_WAIT = 24'd328000;

  // Power-up sequence steps.
  localparam logic [3:0] STEP_PWR_WAIT   = 4'd0;
  localparam logic [3:0] STEP_WAKE1      = 4'd1;
  localparam logic [3:0] STEP_WAKE2_WAIT = 4'd2;
  localparam logic [3:0] STEP_WAKE2      = 4'd3;
  localparam logic [3:0] STEP_WAKE3_WAIT = 4'd4;
  localparam logic [3:0] STEP_WAKE3      = 4'd5;
  localparam logic [3:0] STEP_MODE4      = 4'd6;
  localparam logic [3:0] STEP_FUNC_SET   = 4'd7;
  localparam logic [3:0] STEP_DISP_ON    = 4'd8;
  localparam logic [3:0] STEP_CLEAR      = 4'd9;
  localparam logic [3:0] STEP_CLEAR_WAIT = 4'd10;
  localparam logic [3:0] STEP_ENTRY      = 4'd11;
  localparam logic [3:0] STEP_DONE       = 4'd12;

  // Bytes sent during power-up.
  localparam logic [7:0] BYTE_WAKE      = 8'h33;
  localparam logic [7:0] BYTE_MODE4     = 8'h22;
  localparam logic [7:0] BYTE_FUNC_SET  = 8'b0010_1000;
  localparam logic [7:0] BYTE_DISP_ON   = 8'b0000_1101;
  localparam logic [7:0] BYTE_CLEAR     = 8'h01;
  localparam logic [7:0] BYTE_ENTRY     = 8'b0000_0110;

  // Depth of the small queues, and the count that marks them full.
  localparam logic [1:0] Q_FULL = 2'd2;

  // Sequencer phases.
  typedef enum logic [4:0] {
    PH_WAIT   = 5'b00001,
    PH_SETUP  = 5'b00010,
    PH_ENABLE = 5'b00100,
    PH_HOLD   = 5'b01000,
    PH_READY  = 5'b10000
  } phase_t;

  // One input item: a tick that may carry a byte write.
  typedef struct packed {
    logic       req_valid;
    logic       req_rs;
    logic [7:0] req_byte;
  } req_item_t;

  // One result item: pin levels and status seen on a tick.
  typedef struct packed {
    logic       rs_pin;
    logic       en_pin;
    logic [3:0] data_pins;
    logic       ready_res;
    logic       init_done;
  } res_item_t;

  // A configuration write.
  typedef struct packed {
    logic                 we;
    logic [CFG_IDX_W-1:0] idx;
    logic [CFG_W-1:0]     data;
  } cfg_wr_t;

  // Saturate a duration to what the tick counter can hold.
  function automatic logic [COUNT_WIDTH-1:0] clip_len(input logic [31:0] d);
    if ({1'b0, d} > CNT_MAX) begin
      return CNT_MAX[COUNT_WIDTH-1:0];
    end
    return d[COUNT_WIDTH-1:0];
  endfunction

endpackage

`default_nettype wire

@@ sv/char_lcd_4bit_write_sequencer_core.sv @@
// A tick item is registered in the front queue, then taken by the sequencer and
// registered in the result queue, whose head drives the out_ ports. The sequencer
// advances one tick per cycle while an item waits and the result queue has room.
// Reset (rst_n low at a clock edge) empties both queues, loads the timing register
// defaults and restarts the power-up sequence at its first wait.
// ---------------------------------------------------------------------------
// char_lcd_4bit_write_sequencer_core
// Character LCD write sequencer for a 4-bit parallel bus: an input queue,
// the power-up and nibble timing sequencer, and a result queue.
// ---------------------------------------------------------------------------
`default_nettype none

module char_lcd_4bit_write_sequencer_core (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  // Tick items.
  input  wire logic                             in_push,
  output logic                                  in_full,
  input  wire logic                             in_req_valid,
  input  wire logic                             in_req_rs,
  input  wire logic [7:0]                       in_req_byte,
  // Result items.
  output logic                                  out_empty,
  input  wire logic                             out_pop,
  output logic                                  out_rs_pin,
  output logic                                  out_en_pin,
  output logic [3:0]                            out_data_pins,
  output logic                                  out_ready_res,
  output logic                                  out_init_done,
  // Timing register writes.
  input  wire logic                             cfg_we,
  input  wire logic [clwseq_pkg::CFG_IDX_W-1:0] cfg_idx,
  input  wire logic [clwseq_pkg::CFG_W-1:0]     cfg_wdata
);

  clwseq_pkg::req_item_t in_item, q_item;
  clwseq_pkg::res_item_t res_item, out_item;
  clwseq_pkg::cfg_wr_t   cfg_wr;
  logic                  q_avail, q_pop;
  logic                  res_push, res_full;

  assign in_item.req_valid = in_req_valid;
  assign in_item.req_rs    = in_req_rs;
  assign in_item.req_byte  = in_req_byte;

  assign cfg_wr.we   = cfg_we;
  assign cfg_wr.idx  = cfg_idx;
  assign cfg_wr.data = cfg_wdata;

  clwseq_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (in_push),
    .full_o  (in_full),
    .item_i  (in_item),
    .avail_o (q_avail),
    .pop_i   (q_pop),
    .item_o  (q_item)
  );

  clwseq_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_i      (cfg_wr),
    .in_avail_i (q_avail),
    .in_item_i  (q_item),
    .in_pop_o   (q_pop),
    .res_full_i (res_full),
    .res_push_o (res_push),
    .res_item_o (res_item)
  );

  clwseq_outq u_outq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (res_push),
    .item_i  (res_item),
    .full_o  (res_full),
    .empty_o (out_empty),
    .pop_i   (out_pop),
    .item_o  (out_item)
  );

  assign out_rs_pin    = out_item.rs_pin;
  assign out_en_pin    = out_item.en_pin;
  assign out_data_pins = out_item.data_pins;
  assign out_ready_res = out_item.ready_res;
  assign out_init_done = out_item.init_done;

endmodule

`default_nettype wire

@@ sv/clwseq_front.sv @@
// ---------------------------------------------------------------------------
// clwseq_front
// Input side: takes tick items from the producer into a two-entry queue and
// clears the payload of each plain tick before the sequencer sees it.
// ---------------------------------------------------------------------------
`default_nettype none

module clwseq_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push_i,
  output logic                       full_o,
  input  wire clwseq_pkg::req_item_t item_i,
  output logic                       avail_o,
  input  wire logic                  pop_i,
  output clwseq_pkg::req_item_t      item_o
);

  clwseq_pkg::req_item_t ent_r [2];
  clwseq_pkg::req_item_t ent_nxt;
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  wr_ptr_r, rd_ptr_r;
  logic                  do_push, do_pop;

  assign do_push = push_i && (cnt_r != clwseq_pkg::Q_FULL);
  assign do_pop  = pop_i && (cnt_r != 2'd0);

  // A plain tick keeps no byte: its payload is cleared so that only
  // write requests carry data into the sequencer.
  always_comb begin
    ent_nxt = item_i;
    if (!item_i.req_valid) begin
      ent_nxt.req_rs   = 1'b0;
      ent_nxt.req_byte = 8'd0;
    end
  end

  always_comb begin
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= ent_nxt;
    end
  end

  assign full_o  = (cnt_r == clwseq_pkg::Q_FULL);
  assign avail_o = (cnt_r != 2'd0);
  assign item_o  = ent_r[rd_ptr_r];

endmodule

`default_nettype wire

@@ sv/clwseq_back.sv @@
// ---------------------------------------------------------------------------
// clwseq_back
// Sequencer: runs the power-up sequence and the nibble timing of byte
// writes, one tick per item taken from the front queue, and pushes one
// result item per tick into the result queue.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module clwseq_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire clwseq_pkg::cfg_wr_t   cfg_i,
  input  wire logic                  in_avail_i,
  input  wire clwseq_pkg::req_item_t in_item_i,
  output logic                       in_pop_o,
  input  wire logic                  res_full_i,
  output logic                       res_push_o,
  output clwseq_pkg::res_item_t      res_item_o
);

  // Timing registers.
  logic [15:0] setup_r, enable_r, hold_r;
  logic [23:0] pwr_wait_r, wake2_wait_r, wake3_wait_r, clr_wait_r;

  // Sequencer state.
  clwseq_pkg::phase_t                 phase_r, phase_nxt;
  logic [clwseq_pkg::COUNT_WIDTH-1:0] cnt_r, cnt_nxt;
  logic [3:0]                         step_r, step_nxt;
  logic [7:0]                         held_r, held_nxt;
  logic                               held_rs_r, held_rs_nxt;
  logic                               low_r, low_nxt;
  logic                               init_fin_r, init_fin_nxt;
  logic                               pin_rs_r, pin_rs_nxt;
  logic                               pin_en_r, pin_en_nxt;
  logic [3:0]                         pin_data_r, pin_data_nxt;
  logic                               ready;
  logic                               step_en;

  logic [clwseq_pkg::COUNT_WIDTH-1:0] setup_len, hold_len, en_len;

  // Length of the timed wait that belongs to a power-up step.
  function automatic logic [clwseq_pkg::COUNT_WIDTH-1:0] wait_len(
    input logic [3:0]  s,
    input logic [23:0] pw,
    input logic [23:0] w2,
    input logic [23:0] w3,
    input logic [23:0] cw
  );
    case (s)
      clwseq_pkg::STEP_PWR_WAIT:   return clwseq_pkg::clip_len(32'(pw));
      clwseq_pkg::STEP_WAKE2_WAIT: return clwseq_pkg::clip_len(32'(w2));
      clwseq_pkg::STEP_WAKE3_WAIT: return clwseq_pkg::clip_len(32'(w3));
      clwseq_pkg::STEP_CLEAR_WAIT: return clwseq_pkg::clip_len(32'(cw));
      default:                     return '0;
    endcase
  endfunction

  // One tick is taken whenever an item waits and the result has room.
  assign step_en    = in_avail_i && !res_full_i;
  assign in_pop_o   = step_en;
  assign res_push_o = step_en;

  assign setup_len = clwseq_pkg::clip_len(32'(setup_r));
  assign hold_len  = clwseq_pkg::clip_len(32'(hold_r));

  // Enable time of zero behaves as one tick.
  always_comb begin
    en_len = clwseq_pkg::clip_len(32'(enable_r));
    if (en_len == '0) begin
      en_len = clwseq_pkg::CNT_ONE;
    end
  end

  // Next state of one tick. The phase case raises events, and the chain
  // below resolves them in order, so zero-length phases pass within a tick.
  always_comb begin
    logic                               do_enable, do_hold, do_ndone;
    logic                               do_init, do_start, do_load;
    logic [7:0]                         ld_byte;
    logic                               ld_two;
    logic [3:0]                         s;
    logic [clwseq_pkg::COUNT_WIDTH-1:0] cnt_inc;

    do_enable    = 1'b0;
    do_hold      = 1'b0;
    do_ndone     = 1'b0;
    do_init      = 1'b0;
    do_start     = 1'b0;
    do_load      = 1'b0;
    ld_byte      = 8'd0;
    ld_two       = 1'b0;
    s            = step_r;
    cnt_inc      = cnt_r + clwseq_pkg::CNT_ONE;

    phase_nxt    = phase_r;
    cnt_nxt      = cnt_r;
    step_nxt     = step_r;
    held_nxt     = held_r;
    held_rs_nxt  = held_rs_r;
    low_nxt      = low_r;
    init_fin_nxt = init_fin_r;
    pin_rs_nxt   = pin_rs_r;
    pin_en_nxt   = pin_en_r;
    pin_data_nxt = pin_data_r;
    ready        = 1'b0;

    case (phase_r)
      clwseq_pkg::PH_WAIT: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= wait_len(step_r, pwr_wait_r, wake2_wait_r, wake3_wait_r,
                                clr_wait_r)) begin
          step_nxt = step_r + 4'd1;
          do_init  = 1'b1;
        end
      end
      clwseq_pkg::PH_SETUP: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= setup_len) begin
          do_enable = 1'b1;
        end
      end
      clwseq_pkg::PH_ENABLE: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= en_len) begin
          do_hold = 1'b1;
        end
      end
      clwseq_pkg::PH_HOLD: begin
        cnt_nxt = cnt_inc;
        if (cnt_inc >= hold_len) begin
          do_ndone = 1'b1;
        end
      end
      default: begin
        // Idle: a write request is taken and its high nibble started.
        phase_nxt = clwseq_pkg::PH_READY;
        if (in_item_i.req_valid) begin
          ready       = 1'b1;
          held_nxt    = in_item_i.req_byte;
          held_rs_nxt = in_item_i.req_rs;
          low_nxt     = 1'b1;
          do_start    = 1'b1;
        end
      end
    endcase

    // Enable falls, then the hold wait.
    if (do_hold) begin
      phase_nxt  = clwseq_pkg::PH_HOLD;
      cnt_nxt    = '0;
      pin_en_nxt = 1'b0;
      if (hold_len == '0) begin
        do_ndone = 1'b1;
      end
    end

    // A nibble has finished: send the low half, go on with power-up, or idle.
    if (do_ndone) begin
      if (low_nxt) begin
        low_nxt  = 1'b0;
        do_start = 1'b1;
      end else if (!init_fin_nxt) begin
        step_nxt = step_nxt + 4'd1;
        do_init  = 1'b1;
      end else begin
        phase_nxt = clwseq_pkg::PH_READY;
        cnt_nxt   = '0;
      end
    end

    // Start the next power-up step. A wait of zero passes on to the nibble
    // step that follows it.
    if (do_init) begin
      s = step_nxt;
      if ((s inside {clwseq_pkg::STEP_PWR_WAIT, clwseq_pkg::STEP_WAKE2_WAIT,
                     clwseq_pkg::STEP_WAKE3_WAIT, clwseq_pkg::STEP_CLEAR_WAIT}) &&
          (wait_len(s, pwr_wait_r, wake2_wait_r, wake3_wait_r, clr_wait_r) != '0)) begin
        phase_nxt = clwseq_pkg::PH_WAIT;
        cnt_nxt   = '0;
      end else begin
        if (s inside {clwseq_pkg::STEP_PWR_WAIT, clwseq_pkg::STEP_WAKE2_WAIT,
                      clwseq_pkg::STEP_WAKE3_WAIT, clwseq_pkg::STEP_CLEAR_WAIT}) begin
          s = s + 4'd1;
        end
        case (s)
          clwseq_pkg::STEP_WAKE1, clwseq_pkg::STEP_WAKE2, clwseq_pkg::STEP_WAKE3: begin
            do_load = 1'b1;
            ld_byte = clwseq_pkg::BYTE_WAKE;
            ld_two  = 1'b0;
          end
          clwseq_pkg::STEP_MODE4: begin
            do_load = 1'b1;
            ld_byte = clwseq_pkg::BYTE_MODE4;
            ld_two  = 1'b0;
          end
          clwseq_pkg::STEP_FUNC_SET: begin
            do_load = 1'b1;
            ld_byte = clwseq_pkg::BYTE_FUNC_SET;
            ld_two  = 1'b1;
          end
          clwseq_pkg::STEP_DISP_ON: begin
            do_load = 1'b1;
            ld_byte = clwseq_pkg::BYTE_DISP_ON;
            ld_two  = 1'b1;
          end
          clwseq_pkg::STEP_CLEAR: begin
            do_load = 1'b1;
            ld_byte = clwseq_pkg::BYTE_CLEAR;
            ld_two  = 1'b1;
          end
          clwseq_pkg::STEP_ENTRY: begin
            do_load = 1'b1;
            ld_byte = clwseq_pkg::BYTE_ENTRY;
            ld_two  = 1'b1;
          end
          default: begin
            s            = clwseq_pkg::STEP_DONE;
            init_fin_nxt = 1'b1;
            phase_nxt    = clwseq_pkg::PH_READY;
            cnt_nxt      = '0;
          end
        endcase
      end
      step_nxt = s;
    end

    // Load a power-up byte; commands always go with RS low.
    if (do_load) begin
      held_nxt    = ld_byte;
      held_rs_nxt = 1'b0;
      low_nxt     = ld_two;
      do_start    = 1'b1;
    end

    // Drive RS, then the setup wait.
    if (do_start) begin
      phase_nxt  = clwseq_pkg::PH_SETUP;
      cnt_nxt    = '0;
      pin_rs_nxt = held_rs_nxt;
      if (setup_len == '0) begin
        do_enable = 1'b1;
      end
    end

    // Enable rises with the nibble on the data pins.
    if (do_enable) begin
      phase_nxt    = clwseq_pkg::PH_ENABLE;
      cnt_nxt      = '0;
      pin_en_nxt   = 1'b1;
      pin_data_nxt = low_nxt ? held_nxt[7:4] : held_nxt[3:0];
    end
  end

  // Sequencer registers advance once per tick item.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= clwseq_pkg::PH_WAIT;
      cnt_r      <= '0;
      step_r     <= clwseq_pkg::STEP_PWR_WAIT;
      held_r     <= 8'd0;
      held_rs_r  <= 1'b0;
      low_r      <= 1'b0;
      init_fin_r <= 1'b0;
      pin_rs_r   <= 1'b0;
      pin_en_r   <= 1'b0;
      pin_data_r <= 4'd0;
    end else if (step_en) begin
      phase_r    <= phase_nxt;
      cnt_r      <= cnt_nxt;
      step_r     <= step_nxt;
      held_r     <= held_nxt;
      held_rs_r  <= held_rs_nxt;
      low_r      <= low_nxt;
      init_fin_r <= init_fin_nxt;
      pin_rs_r   <= pin_rs_nxt;
      pin_en_r   <= pin_en_nxt;
      pin_data_r <= pin_data_nxt;
    end
  end

  // Timing register writes; an index past the list is dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setup_r      <= clwseq_pkg::RST_SETUP;
      enable_r     <= clwseq_pkg::RST_ENABLE;
      hold_r       <= clwseq_pkg::RST_HOLD;
      pwr_wait_r   <= clwseq_pkg::RST_POWER_WAIT;
      wake2_wait_r <= clwseq_pkg::RST_WAKE2_WAIT;
      wake3_wait_r <= clwseq_pkg::RST_WAKE3_WAIT;
      clr_wait_r   <= clwseq_pkg::RST_CLEAR_WAIT;
    end else if (cfg_i.we) begin
      case (cfg_i.idx)
        clwseq_pkg::REG_SETUP:      setup_r      <= cfg_i.data[15:0];
        clwseq_pkg::REG_ENABLE:     enable_r     <= cfg_i.data[15:0];
        clwseq_pkg::REG_HOLD:       hold_r       <= cfg_i.data[15:0];
        clwseq_pkg::REG_POWER_WAIT: pwr_wait_r   <= cfg_i.data;
        clwseq_pkg::REG_WAKE2_WAIT: wake2_wait_r <= cfg_i.data;
        clwseq_pkg::REG_WAKE3_WAIT: wake3_wait_r <= cfg_i.data;
        clwseq_pkg::REG_CLEAR_WAIT: clr_wait_r   <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // The result shows the pin levels from before this tick.
  assign res_item_o.rs_pin    = pin_rs_r;
  assign res_item_o.en_pin    = pin_en_r;
  assign res_item_o.data_pins = pin_data_r;
  assign res_item_o.ready_res = ready;
  assign res_item_o.init_done = init_fin_r;

  // Enable is high exactly while the sequencer sits in the enable phase.
  `CLW_ASSERT(a_en_phase, pin_en_r == (phase_r == clwseq_pkg::PH_ENABLE),
              "enable pin out of step with enable phase")
  // Once the power-up sequence is over it stays over.
  `CLW_ASSERT_NEXT(a_init_sticky, init_fin_r, init_fin_r, "init_done fell")
  // A request is only taken from idle after power-up.
  `CLW_ASSERT(a_ready_idle,
              !ready || (init_fin_r && (phase_r == clwseq_pkg::PH_READY)),
              "request taken while busy")

endmodule

`default_nettype wire

@@ sv/clwseq_outq.sv @@
// ---------------------------------------------------------------------------
// clwseq_outq
// Result side: a two-entry queue that holds result items until the
// consumer pops them, so the sequencer keeps running while one waits.
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module clwseq_outq (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  push_i,
  input  wire clwseq_pkg::res_item_t item_i,
  output logic                       full_o,
  output logic                       empty_o,
  input  wire logic                  pop_i,
  output clwseq_pkg::res_item_t      item_o
);

  clwseq_pkg::res_item_t ent_r [2];
  logic [1:0]            cnt_r, cnt_nxt;
  logic                  wr_ptr_r, rd_ptr_r;
  logic                  do_push, do_pop;

  assign do_push = push_i && (cnt_r != clwseq_pkg::Q_FULL);
  assign do_pop  = pop_i && (cnt_r != 2'd0);

  always_comb begin
    cnt_nxt = cnt_r;
    case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + 2'd1;
      2'b01:   cnt_nxt = cnt_r - 2'd1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  // Queue pointers and fill count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= 2'd0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= item_i;
    end
  end

  assign full_o  = (cnt_r == clwseq_pkg::Q_FULL);
  assign empty_o = (cnt_r == 2'd0);
  assign item_o  = ent_r[rd_ptr_r];

  // The sequencer never offers a result while the queue is full.
  `CLW_ASSERT(a_no_overflow, !(push_i && (cnt_r == clwseq_pkg::Q_FULL)),
              "result pushed into full queue")

endmodule

`default_nettype wire
